[design/stdir_pkg.sv]
// ----------------------------------------------------------------------------
// stdir_pkg
// Shared types and constants of the slot table directory.
// ----------------------------------------------------------------------------
package stdir_pkg;

	localparam int TableDepth = 64;
	localparam int IdxW       = $clog2(TableDepth);
	localparam int SlotW      = 6;
	localparam int CountW     = 7;
	localparam int KeyBytes   = 19;

	typedef struct packed {
		logic [23:0] w2;
		logic [63:0] w1;
		logic [63:0] w0;
	} key_t;

	typedef struct packed {
		key_t surname;
		key_t name;
		key_t number;
	} entry_t;

	localparam int EntryW = $bits(entry_t);

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_LIST   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

endpackage

[design/slot_table_directory.sv]
// ----------------------------------------------------------------------------
// slot_table_directory
// Phone directory in a fixed slot table: add, delete, search and list.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Add on a full table
// and delete, search or list on an empty one answer with an error in the
// cycle right after start and never raise busy. Otherwise busy rises. An add
// walks the valid map one slot per cycle and answers with the slot it takes.
// Delete, search and list walk the entry memory one slot per cycle through
// its single read port, whose read data is registered, and compare each slot
// on that registered data. Busy falls in the cycle that carries the final
// result, so the next request can be taken at the edge that ends that cycle.
// Each result shows for one cycle with strobe high; a list gives at most one
// result per cycle, with last set on the final one. The receiver cannot stall
// results.
module slot_table_directory (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [63:0] number_w0,
	input  logic [63:0] number_w1,
	input  logic [23:0] number_w2,
	input  logic [63:0] name_w0,
	input  logic [63:0] name_w1,
	input  logic [23:0] name_w2,
	input  logic [63:0] surname_w0,
	input  logic [63:0] surname_w1,
	input  logic [23:0] surname_w2,
	output logic        strobe,
	output logic [1:0]  status,
	output logic [5:0]  slot,
	output logic [63:0] out_number_w0,
	output logic [63:0] out_number_w1,
	output logic [23:0] out_number_w2,
	output logic [63:0] out_name_w0,
	output logic [63:0] out_name_w1,
	output logic [23:0] out_name_w2,
	output logic [63:0] out_surname_w0,
	output logic [63:0] out_surname_w1,
	output logic [23:0] out_surname_w2,
	output logic        last
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADD,
		S_SCAN
	} state_t;

	state_t                            state_q;
	stdir_pkg::req_t                   req_q;
	stdir_pkg::entry_t                 key_q;
	stdir_pkg::entry_t                 key_in;
	stdir_pkg::entry_t                 rd_entry;
	logic [stdir_pkg::EntryW-1:0]      rd_data;
	logic [stdir_pkg::TableDepth-1:0]  valid_q;
	logic [stdir_pkg::CountW-1:0]      count_q;
	logic [stdir_pkg::CountW-1:0]      emit_cnt_q;
	logic [stdir_pkg::IdxW-1:0]        idx_q;
	logic                              issue_q;
	logic                              vld_s1;
	logic [stdir_pkg::IdxW-1:0]        idx_s1;

	logic                              strobe_q;
	logic                              last_q;
	stdir_pkg::status_t                status_q;
	logic [stdir_pkg::SlotW-1:0]       slot_q;
	stdir_pkg::entry_t                 res_q;

	logic                              accept;
	logic                              ram_we;
	logic                              ram_re;
	logic                              idx_end;
	logic                              s1_end;
	logic                              s1_valid;
	logic                              s1_match;
	logic                              list_last;

	stdir_norm u_norm_number (
		.raw(stdir_pkg::key_t'({number_w2, number_w1, number_w0})),
		.key(key_in.number)
	);

	stdir_norm u_norm_name (
		.raw(stdir_pkg::key_t'({name_w2, name_w1, name_w0})),
		.key(key_in.name)
	);

	stdir_norm u_norm_surname (
		.raw(stdir_pkg::key_t'({surname_w2, surname_w1, surname_w0})),
		.key(key_in.surname)
	);

	assign accept  = start && (state_q == S_IDLE);
	assign ram_we  = (state_q == S_ADD) && !valid_q[idx_q];
	assign ram_re  = (state_q == S_SCAN) && issue_q;
	assign idx_end = idx_q == stdir_pkg::IdxW'(stdir_pkg::TableDepth - 1);
	assign s1_end  = idx_s1 == stdir_pkg::IdxW'(stdir_pkg::TableDepth - 1);

	stdir_ram #(
		.Width(stdir_pkg::EntryW),
		.Depth(stdir_pkg::TableDepth)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(key_q),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	assign rd_entry  = stdir_pkg::entry_t'(rd_data);
	assign s1_valid  = vld_s1 && valid_q[idx_s1];
	assign s1_match  = rd_entry.number == key_q.number;
	assign list_last = (emit_cnt_q + stdir_pkg::CountW'(1)) == count_q;

	// key capture; payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_q      <= stdir_pkg::REQ_ADD;
			valid_q    <= '0;
			count_q    <= '0;
			emit_cnt_q <= '0;
			idx_q      <= '0;
			issue_q    <= 1'b0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			strobe_q   <= 1'b0;
			last_q     <= 1'b0;
			status_q   <= stdir_pkg::ST_OK;
			slot_q     <= '0;
			res_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (start) begin
						req_q      <= stdir_pkg::req_t'(req_type);
						idx_q      <= '0;
						issue_q    <= 1'b1;
						emit_cnt_q <= '0;
						if (stdir_pkg::req_t'(req_type) == stdir_pkg::REQ_ADD) begin
							if (count_q >= stdir_pkg::CountW'(stdir_pkg::TableDepth)) begin
								strobe_q <= 1'b1;
								last_q   <= 1'b1;
								status_q <= stdir_pkg::ST_FULL;
								slot_q   <= '0;
								res_q    <= '0;
							end else begin
								state_q <= S_ADD;
							end
						end else if (count_q == '0) begin
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
							status_q <= stdir_pkg::ST_EMPTY;
							slot_q   <= '0;
							res_q    <= '0;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end

				S_ADD: begin
					if (!valid_q[idx_q]) begin
						valid_q[idx_q] <= 1'b1;
						count_q        <= count_q + stdir_pkg::CountW'(1);
						strobe_q       <= 1'b1;
						last_q         <= 1'b1;
						status_q       <= stdir_pkg::ST_OK;
						slot_q         <= stdir_pkg::SlotW'(idx_q);
						res_q          <= '0;
						state_q        <= S_IDLE;
					end else if (idx_end) begin
						strobe_q <= 1'b1;
						last_q   <= 1'b1;
						status_q <= stdir_pkg::ST_FULL;
						slot_q   <= '0;
						res_q    <= '0;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_q + stdir_pkg::IdxW'(1);
					end
				end

				S_SCAN: begin
					// read issue stage
					if (issue_q) begin
						idx_q <= idx_q + stdir_pkg::IdxW'(1);
						if (idx_end) begin
							issue_q <= 1'b0;
						end
					end
					vld_s1 <= issue_q;
					idx_s1 <= idx_q;

					// compare stage on registered read data
					if (vld_s1) begin
						if (req_q == stdir_pkg::REQ_LIST) begin
							if (s1_valid) begin
								strobe_q   <= 1'b1;
								last_q     <= list_last;
								status_q   <= stdir_pkg::ST_OK;
								slot_q     <= stdir_pkg::SlotW'(idx_s1);
								res_q      <= rd_entry;
								emit_cnt_q <= emit_cnt_q + stdir_pkg::CountW'(1);
							end
							if ((s1_valid && list_last) || s1_end) begin
								state_q <= S_IDLE;
							end
						end else if (s1_valid && s1_match) begin
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
							status_q <= stdir_pkg::ST_OK;
							slot_q   <= stdir_pkg::SlotW'(idx_s1);
							if (req_q == stdir_pkg::REQ_DELETE) begin
								valid_q[idx_s1] <= 1'b0;
								count_q         <= count_q - stdir_pkg::CountW'(1);
								res_q           <= '0;
							end else begin
								res_q <= rd_entry;
							end
							state_q <= S_IDLE;
						end else if (s1_end) begin
							strobe_q <= 1'b1;
							last_q   <= 1'b1;
							status_q <= stdir_pkg::ST_NOT_FOUND;
							slot_q   <= '0;
							res_q    <= '0;
							state_q  <= S_IDLE;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = state_q != S_IDLE;
	assign strobe         = strobe_q;
	assign last           = last_q;
	assign status         = status_q;
	assign slot           = slot_q;
	assign out_number_w0  = res_q.number.w0;
	assign out_number_w1  = res_q.number.w1;
	assign out_number_w2  = res_q.number.w2;
	assign out_name_w0    = res_q.name.w0;
	assign out_name_w1    = res_q.name.w1;
	assign out_name_w2    = res_q.name.w2;
	assign out_surname_w0 = res_q.surname.w0;
	assign out_surname_w1 = res_q.surname.w1;
	assign out_surname_w2 = res_q.surname.w2;

	// the entry count always tracks the valid map
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == stdir_pkg::CountW'($countones(valid_q)))
		else $error("entry count out of step with valid map");

	// the final result of a request leaves the block ready for the next one
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy still high after final result");

	// an accepted request either answers at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || strobe)
		else $error("request dropped");

	// error results are final and carry slot zero
	a_error_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != stdir_pkg::ST_OK) |-> last && (slot == '0))
		else $error("malformed error result");

endmodule

[design/stdir_ram.sv]
// ----------------------------------------------------------------------------
// stdir_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stdir_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/stdir_norm.sv]
// ----------------------------------------------------------------------------
// stdir_norm
// Key normalizer: clears every byte after the first zero byte of a key.
// ----------------------------------------------------------------------------
module stdir_norm (
	input  stdir_pkg::key_t raw,
	output stdir_pkg::key_t key
);

	logic [stdir_pkg::KeyBytes*8-1:0] flat_in;
	logic [stdir_pkg::KeyBytes*8-1:0] flat_out;

	assign flat_in = raw;

	always_comb begin
		logic alive;
		alive    = 1'b1;
		flat_out = '0;
		for (int k = 0; k < stdir_pkg::KeyBytes; k++) begin
			if (flat_in[8*k +: 8] == 8'd0) begin
				alive = 1'b0;
			end
			if (alive) begin
				flat_out[8*k +: 8] = flat_in[8*k +: 8];
			end
		end
	end

	assign key = stdir_pkg::key_t'(flat_out);

endmodule
